// ----- src/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the crc-16 byte step for the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  STUFF_A    = 8'hFC;
    localparam logic [7:0]  STUFF_B    = 8'hFE;
    localparam logic [7:0]  STUFF_FILL = 8'h00;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF   = 2;

    typedef enum logic [1:0] {
        REG_START_WORD     = 2'd0,
        REG_SOURCE_ADDRESS = 2'd1,
        REG_DEST_ADDRESS   = 2'd2,
        REG_STOP_WORD      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_last;
    } payload_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
    } result_t;

    // one queued payload byte, tagged by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;
    } item_t;

    typedef struct packed {
        logic [15:0] start_word;
        logic [7:0]  source_address;
        logic [7:0]  destination_address;
        logic [15:0] stop_word;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_ENTRY,
        PH_START_HI,
        PH_START_LO,
        PH_SRC,
        PH_DST,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_STOP_HI,
        PH_STOP_LO
    } phase_t;

    // reflected crc-16, one byte
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- src/cfb_fifo.sv -----
// ----------------------------------------------------------------------------
// cfb_fifo
// Small register queue with a combinational head, used between the stages.
// ----------------------------------------------------------------------------
module cfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- src/cfb_front.sv -----
// ----------------------------------------------------------------------------
// cfb_front
// Accepts payload beats and tags each one that opens a new frame.
// ----------------------------------------------------------------------------
module cfb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfb_pkg::payload_t payload,
    input  logic              q_full,
    output logic              full,
    output logic              q_wr,
    output cfb_pkg::item_t    q_data
);
    import cfb_pkg::*;

    logic in_frame_reg, in_frame_next;

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        q_data.data  = payload.payload_byte;
        q_data.last  = payload.payload_last;
        q_data.first = !in_frame_reg;
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        if (q_wr)
        begin
            in_frame_next = !payload.payload_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

// ----- src/cfb_back.sv -----
// ----------------------------------------------------------------------------
// cfb_back
// Sequencer: header, payload, crc, stop bytes (stop unstuffed); one per cycle unless q_empty or out_full.
// ----------------------------------------------------------------------------
module cfb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  cfb_pkg::cfg_t    cfg,
    input  cfb_pkg::item_t   head,
    input  logic             q_empty,
    output logic             q_rd,
    input  logic             out_full,
    output logic             out_wr,
    output cfb_pkg::result_t out_data
);
    import cfb_pkg::*;

    phase_t      phase_reg, phase_next;
    phase_t      eff_phase, follow_phase;
    logic        stuff_reg, stuff_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_base;
    logic [7:0]  cur_byte;
    logic        fire, stuff_need, feeds_crc, is_stop;

    // entry resolves from the head item, so a new item starts without a bubble
    always_comb
    begin
        if (phase_reg == PH_ENTRY)
        begin
            eff_phase = head.first ? PH_START_HI : PH_DATA;
        end
        else
        begin
            eff_phase = phase_reg;
        end
    end

    always_comb
    begin
        unique case (eff_phase)
            PH_START_HI: follow_phase = PH_START_LO;
            PH_START_LO: follow_phase = PH_SRC;
            PH_SRC:      follow_phase = PH_DST;
            PH_DST:      follow_phase = PH_DATA;
            PH_DATA:     follow_phase = head.last ? PH_CRC_HI : PH_ENTRY;
            PH_CRC_HI:   follow_phase = PH_CRC_LO;
            PH_CRC_LO:   follow_phase = PH_STOP_HI;
            PH_STOP_HI:  follow_phase = PH_STOP_LO;
            default:     follow_phase = PH_ENTRY;
        endcase
    end

    always_comb
    begin
        unique case (eff_phase)
            PH_START_HI: cur_byte = cfg.start_word[15:8];
            PH_START_LO: cur_byte = cfg.start_word[7:0];
            PH_SRC:      cur_byte = cfg.source_address;
            PH_DST:      cur_byte = cfg.destination_address;
            PH_CRC_HI:   cur_byte = crc_reg[15:8];
            PH_CRC_LO:   cur_byte = crc_reg[7:0];
            PH_STOP_HI:  cur_byte = cfg.stop_word[15:8];
            PH_STOP_LO:  cur_byte = cfg.stop_word[7:0];
            default:     cur_byte = head.data;
        endcase
    end

    assign fire       = !q_empty && !out_full;
    assign is_stop    = (eff_phase == PH_STOP_HI) || (eff_phase == PH_STOP_LO);
    assign stuff_need = !stuff_reg && !is_stop
                        && ((cur_byte == STUFF_A) || (cur_byte == STUFF_B));
    assign feeds_crc  = !stuff_reg && ((eff_phase == PH_START_HI) || (eff_phase == PH_START_LO)
                        || (eff_phase == PH_SRC) || (eff_phase == PH_DST)
                        || (eff_phase == PH_DATA));
    assign crc_base   = (eff_phase == PH_START_HI) ? CRC_INIT : crc_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        stuff_next = stuff_reg;
        crc_next   = crc_reg;
        if (fire)
        begin
            stuff_next = stuff_need;
            phase_next = stuff_need ? eff_phase : follow_phase;
            if (feeds_crc)
            begin
                crc_next = crc16_feed(crc_base, cur_byte);
            end
        end
    end

    // outputs
    always_comb
    begin
        out_wr             = fire;
        q_rd               = fire && !stuff_need && (follow_phase == PH_ENTRY);
        out_data.line_byte = stuff_reg ? STUFF_FILL : cur_byte;
        out_data.frame_end = !stuff_reg && (eff_phase == PH_STOP_LO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ENTRY;
            stuff_reg <= 1'b0;
            crc_reg   <= CRC_INIT;
        end
        else
        begin
            phase_reg <= phase_next;
            stuff_reg <= stuff_next;
            crc_reg   <= crc_next;
        end
    end

endmodule

// ----- src/crc16_frame_builder_with_stuffing_core.sv -----
// ----------------------------------------------------------------------------
// crc16_frame_builder_with_stuffing_core
// Frame builder: start word, addresses, payload, crc-16 and stop word, stuffed but for the stop word.
// ----------------------------------------------------------------------------
// The output side moves one line byte per cycle while an item is queued and the result queue
// has room. A payload beat gives one line byte, two when it is 0xFC or 0xFE and takes a filler
// byte; the first beat of a frame adds 4 to 8 header bytes and the last adds 4 to 6 crc and stop
// bytes. That single byte-wide sequencer sets the rate; a payload queue in front of it takes new
// beats while it works, and a small result queue behind it takes bytes while the reader is
// stalled. The user must write registers only while the block is idle; the block does not enforce it.
module crc16_frame_builder_with_stuffing_core #(
    parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = cfb_pkg::OUT_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  cfb_pkg::payload_t payload,
    output logic              empty,
    input  logic              pop,
    output cfb_pkg::result_t  result,
    input  logic              cfg_write,
    input  cfb_pkg::cfg_reg_t cfg_index,
    input  logic [15:0]       cfg_data
);
    import cfb_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    item_t   q_in, q_head;
    logic    q_wr, q_rd, q_full, q_empty;
    logic    out_wr, out_full;
    result_t out_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_WORD:     cfg_next.start_word          = cfg_data;
                REG_SOURCE_ADDRESS: cfg_next.source_address      = cfg_data[7:0];
                REG_DEST_ADDRESS:   cfg_next.destination_address = cfg_data[7:0];
                REG_STOP_WORD:      cfg_next.stop_word           = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cfb_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .payload (payload),
        .q_full  (q_full),
        .full    (full),
        .q_wr    (q_wr),
        .q_data  (q_in)
    );

    cfb_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_in),
        .rd      (q_rd),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    cfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_rd     (q_rd),
        .out_full (out_full),
        .out_wr   (out_wr),
        .out_data (out_data)
    );

    cfb_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_wr),
        .wr_data (out_data),
        .rd      (pop),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty)
    );

    // the sequencer only runs on a queued item
    a_no_beat_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !out_wr)
        else $error("line byte produced with no queued item");

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_full |-> (!out_wr && !q_rd))
        else $error("sequencer advanced while result queue full");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

endmodule
